FILE: hw/rtl/spi_rb_pkg.sv
// spi_rb_pkg: shared types and constants of the spi master register block
// used by spi_rb_core, spi_master_register_block_unit and spi_rb_checker
`default_nettype none

package spi_rb_pkg;

  localparam int unsigned ADDR_W = 12;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned BYTE_W = 8;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [ADDR_W-1:0] OFF_CR1 = 12'h000;
  localparam logic [ADDR_W-1:0] OFF_CR2 = 12'h004;
  localparam logic [ADDR_W-1:0] OFF_SR  = 12'h008;
  localparam logic [ADDR_W-1:0] OFF_DR  = 12'h00C;
  localparam logic [ADDR_W-1:0] OFF_CSC = 12'h010;

  localparam int unsigned CR1_ENABLE_BIT = 6;
  localparam int unsigned CR2_RXNEIE_BIT = 6;
  localparam int unsigned CR2_ERRIE_BIT  = 5;
  localparam int unsigned CR2_TXEIE_BIT  = 7;

  localparam logic [BYTE_W-1:0] SR_RXNE  = 8'h01;
  localparam logic [BYTE_W-1:0] SR_TXE   = 8'h02;
  localparam logic [BYTE_W-1:0] SR_UDR   = 8'h04;
  localparam logic [BYTE_W-1:0] SR_OVR   = 8'h08;
  localparam logic [BYTE_W-1:0] SR_BSY   = 8'h80;
  localparam logic [BYTE_W-1:0] SR_RESET = SR_TXE;

  localparam logic [DATA_W-1:0] CS0_BITS = 32'h0000_0011;
  localparam logic [DATA_W-1:0] CS1_BITS = 32'h0000_0022;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] reg_address;
    logic [DATA_W-1:0] write_data;
    logic [BYTE_W-1:0] miso_byte;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              mosi_valid;
    logic [BYTE_W-1:0] mosi_byte;
    logic              irq_level;
    logic              cs0_n;
    logic              cs1_n;
    logic              bad_offset;
  } rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/spi_rb_core.sv
// spi_rb_core: register file and access decode of the spi master register block
// depends on spi_rb_pkg
`default_nettype none

module spi_rb_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             exec,
  input  wire spi_rb_pkg::req_t req,
  output spi_rb_pkg::rsp_t      rsp
);

  logic [spi_rb_pkg::DATA_W-1:0] control_one;
  logic [spi_rb_pkg::DATA_W-1:0] control_two;
  logic [spi_rb_pkg::BYTE_W-1:0] status_flags;
  logic [spi_rb_pkg::BYTE_W-1:0] rx_byte;
  logic [spi_rb_pkg::DATA_W-1:0] chip_select_control;

  logic [spi_rb_pkg::DATA_W-1:0] control_one_next;
  logic [spi_rb_pkg::DATA_W-1:0] control_two_next;
  logic [spi_rb_pkg::BYTE_W-1:0] status_flags_next;
  logic [spi_rb_pkg::BYTE_W-1:0] rx_byte_next;
  logic [spi_rb_pkg::DATA_W-1:0] chip_select_control_next;
  logic                          irq_rxne;
  logic                          irq_txe;
  logic                          irq_err;

  always_comb begin
    control_one_next         = control_one;
    control_two_next         = control_two;
    status_flags_next        = status_flags;
    rx_byte_next             = rx_byte;
    chip_select_control_next = chip_select_control;
    rsp                      = '0;

    if (req.command == spi_rb_pkg::CMD_WRITE) begin
      case (req.reg_address)
        spi_rb_pkg::OFF_CR1: control_one_next = req.write_data;
        spi_rb_pkg::OFF_CR2: control_two_next = req.write_data;
        spi_rb_pkg::OFF_SR: begin
          status_flags_next = status_flags & ~(req.write_data[spi_rb_pkg::BYTE_W-1:0]
                              & (spi_rb_pkg::SR_UDR | spi_rb_pkg::SR_OVR));
        end
        spi_rb_pkg::OFF_DR: begin
          if (control_one[spi_rb_pkg::CR1_ENABLE_BIT]) begin
            // unread byte still waiting means overrun
            if ((status_flags & spi_rb_pkg::SR_RXNE) != '0) begin
              status_flags_next = status_flags | spi_rb_pkg::SR_OVR;
            end
            status_flags_next = (status_flags_next | spi_rb_pkg::SR_TXE | spi_rb_pkg::SR_RXNE)
                                & ~spi_rb_pkg::SR_BSY;
            rx_byte_next   = req.miso_byte;
            rsp.mosi_valid = 1'b1;
            rsp.mosi_byte  = req.write_data[spi_rb_pkg::BYTE_W-1:0];
          end
        end
        spi_rb_pkg::OFF_CSC: chip_select_control_next = req.write_data;
        default: rsp.bad_offset = 1'b1;
      endcase
    end else begin
      case (req.reg_address)
        spi_rb_pkg::OFF_CR1: rsp.read_data = control_one;
        spi_rb_pkg::OFF_CR2: rsp.read_data = control_two;
        spi_rb_pkg::OFF_SR: begin
          rsp.read_data = {{(spi_rb_pkg::DATA_W-spi_rb_pkg::BYTE_W){1'b0}}, status_flags};
        end
        spi_rb_pkg::OFF_DR: begin
          rsp.read_data = {{(spi_rb_pkg::DATA_W-spi_rb_pkg::BYTE_W){1'b0}}, rx_byte};
          status_flags_next = status_flags & ~spi_rb_pkg::SR_RXNE;
        end
        spi_rb_pkg::OFF_CSC: rsp.read_data = chip_select_control;
        default: rsp.bad_offset = 1'b1;
      endcase
    end

    // outputs reflect state after the access
    irq_rxne = control_two_next[spi_rb_pkg::CR2_RXNEIE_BIT]
               && ((status_flags_next & spi_rb_pkg::SR_RXNE) != '0);
    irq_txe  = control_two_next[spi_rb_pkg::CR2_TXEIE_BIT]
               && ((status_flags_next & spi_rb_pkg::SR_TXE) != '0);
    irq_err  = control_two_next[spi_rb_pkg::CR2_ERRIE_BIT]
               && ((status_flags_next & (spi_rb_pkg::SR_UDR | spi_rb_pkg::SR_OVR)) != '0);
    rsp.irq_level = irq_rxne || irq_txe || irq_err;
    rsp.cs0_n = !((chip_select_control_next & spi_rb_pkg::CS0_BITS) == spi_rb_pkg::CS0_BITS);
    rsp.cs1_n = !((chip_select_control_next & spi_rb_pkg::CS1_BITS) == spi_rb_pkg::CS1_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_one         <= '0;
      control_two         <= '0;
      status_flags        <= spi_rb_pkg::SR_RESET;
      rx_byte             <= '0;
      chip_select_control <= '0;
    end else if (exec) begin
      control_one         <= control_one_next;
      control_two         <= control_two_next;
      status_flags        <= status_flags_next;
      rx_byte             <= rx_byte_next;
      chip_select_control <= chip_select_control_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/spi_master_register_block_unit.sv
// spi_master_register_block_unit: top level, input register, register file, result register
// depends on spi_rb_pkg and spi_rb_core
//
// Register block of a byte-wide spi master, one 32-bit bus access per transfer on req,
// one result per access on rsp. A transfer taken into the input register executes against
// the register file once the result register is free; the register file state and the result
// register are written at the same edge, and one access can be accepted every cycle as long
// as rsp is taken. The single execute stage between the input and result registers sets that
// rate; with rsp stalled, req holds off once both registers are full.
`default_nettype none

module spi_master_register_block_unit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire spi_rb_pkg::req_t req,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output spi_rb_pkg::rsp_t      rsp
);

  logic             req_full;
  spi_rb_pkg::req_t req_q;
  spi_rb_pkg::rsp_t rsp_comb;
  logic             exec;

  assign exec      = req_full && (!rsp_valid || rsp_ready);
  assign req_ready = !req_full || exec;

  spi_rb_core u_core (
    .clk  (clk),
    .rst  (rst),
    .exec (exec),
    .req  (req_q),
    .rsp  (rsp_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (req_ready) begin
      req_full <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || rsp_ready) begin
      rsp_valid <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rsp <= rsp_comb;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/spi_rb_checker.sv
// spi_rb_checker: port-level assertions for spi_master_register_block_unit, bound to the top
// depends on spi_rb_pkg
`default_nettype none

module spi_rb_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             req_ready,
  input wire logic             rsp_valid,
  input wire logic             rsp_ready,
  input wire spi_rb_pkg::rsp_t rsp
);

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // empty output side never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("input stalled with empty output");

  a_bad_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.bad_offset |-> rsp.read_data == '0 && !rsp.mosi_valid)
    else $error("bad offset produced data or transfer");

  a_mosi_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.mosi_valid || rsp.mosi_byte == '0)
                  && (!rsp.mosi_valid || rsp.read_data == '0))
    else $error("inconsistent transfer fields");

endmodule

bind spi_master_register_block_unit spi_rb_checker u_spi_rb_checker (.*);

`default_nettype wire
